>>> rtl/qmst_pkg.sv
// ============================================================================
// qmst_pkg
// Types, constants and the error-probability table for the quality trimmer.
// ============================================================================
`default_nettype none

package qmst_pkg;

    // Read and quality limits
    localparam int MAX_READ_LEN = 4096;
    localparam int MAX_QUALITY  = 99;

    // Field and state widths
    localparam int QUAL_W  = 7;
    localparam int POS_W   = 13;                  // positions up to MAX_READ_LEN
    localparam int IDX_W   = 12;                  // base indexes below MAX_READ_LEN
    localparam int THR_W   = 16;
    localparam int ROM_W   = 17;                  // q = 0 gives exactly 1.0
    localparam int SCORE_W = 28;
    localparam int SUM_W   = SCORE_W + 2;         // signed sum before the clamp
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 1;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [POS_W-1:0]   READ_LIMIT = POS_W'(MAX_READ_LEN);
    localparam logic [QUAL_W-1:0]  QUAL_LIMIT = QUAL_W'(MAX_QUALITY);

    // Register indexes of the configuration port
    localparam logic [ADDR_W-1:0] REG_ERROR_THRESHOLD = 1'b0;
    localparam logic [ADDR_W-1:0] REG_MIN_KEPT_LENGTH = 1'b1;

    // Register reset values
    localparam logic [THR_W-1:0] THR_RESET     = 16'd3277;
    localparam logic [POS_W-1:0] MIN_LEN_RESET = 13'd20;

    // Quality values at or above this give an error word of zero
    localparam int ROM_DEPTH = 60;
    localparam logic [QUAL_W-1:0] ROM_LIMIT = QUAL_W'(ROM_DEPTH);

    // round(65536 * 10^(-q/10)) for q = 0 .. 59
    localparam logic [ROM_W-1:0] ERR_ROM [ROM_DEPTH] = '{
        17'd65536, 17'd52057, 17'd41350, 17'd32846, 17'd26090,
        17'd20724, 17'd16462, 17'd13076, 17'd10387, 17'd8250,
        17'd6554,  17'd5206,  17'd4135,  17'd3285,  17'd2609,
        17'd2072,  17'd1646,  17'd1308,  17'd1039,  17'd825,
        17'd655,   17'd521,   17'd414,   17'd328,   17'd261,
        17'd207,   17'd165,   17'd131,   17'd104,   17'd83,
        17'd66,    17'd52,    17'd41,    17'd33,    17'd26,
        17'd21,    17'd16,    17'd13,    17'd10,    17'd8,
        17'd7,     17'd5,     17'd4,     17'd3,     17'd3,
        17'd2,     17'd2,     17'd1,     17'd1,     17'd1,
        17'd1,     17'd1,     17'd0,     17'd0,     17'd0,
        17'd0,     17'd0,     17'd0,     17'd0,     17'd0
    };

    // Error word for one quality value, saturating the index at MAX_QUALITY
    function automatic logic [ROM_W-1:0] err_word(input logic [QUAL_W-1:0] q);
        logic [QUAL_W-1:0] qs;
        qs = (q > QUAL_LIMIT) ? QUAL_LIMIT : q;
        if (qs < ROM_LIMIT) begin
            return ERR_ROM[qs[5:0]];
        end
        return '0;
    endfunction

    // One base request
    typedef struct packed {
        logic [QUAL_W-1:0] quality;
        logic              last_base;
        logic              enzyme_valid;
        logic [POS_W-1:0]  enzyme_site;
    } qmst_in_t;

    // One trim result
    typedef struct packed {
        logic [POS_W-1:0] left_trim_point;
        logic [POS_W-1:0] right_trim_point;
        logic [IDX_W-1:0] last_kept;
    } qmst_out_t;

endpackage

`default_nettype wire

>>> rtl/quality_max_subsequence_trimmer.sv
// A result is valid after a read's last base passes the input, finish and output
// registers; one base per cycle unless back-pressure holds a last base. The score
// update is one table read, one add with clamp and one compare between the input
// register and the score registers. Reset (aresetn low, synchronous) empties all
// stages, clears read state, loads error_threshold = 3277 and min_kept_length = 20.
// ============================================================================
// quality_max_subsequence_trimmer
// Maximum-scoring-run quality trimmer with enzyme-site start and length filter.
// ============================================================================
`default_nettype none

module quality_max_subsequence_trimmer (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration write port
    input  wire logic                       cfg_wr_en,
    input  wire logic [qmst_pkg::ADDR_W-1:0] cfg_addr,
    input  wire logic [qmst_pkg::CFG_W-1:0]  cfg_wr_data,
    // base requests
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire qmst_pkg::qmst_in_t         s_data,
    // trim results
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output qmst_pkg::qmst_out_t             m_data
);
    import qmst_pkg::*;

    // configuration registers
    logic [THR_W-1:0] thr_reg;
    logic [POS_W-1:0] min_len_reg;

    // input stage
    logic     in_vld_reg;
    qmst_in_t in_reg;

    // read state
    logic [SCORE_W-1:0] run_score_reg, run_score_next;
    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [POS_W-1:0]   run_start_reg, run_start_next;
    logic [POS_W-1:0]   best_begin_reg, best_begin_next;
    logic [IDX_W-1:0]   best_end_reg, best_end_next;
    logic [POS_W-1:0]   count_reg, count_next;

    // finish stage
    logic             fin_vld_reg;
    logic [POS_W-1:0] fin_n_reg;
    logic [POS_W-1:0] fin_beg_reg;
    logic [IDX_W-1:0] fin_end_reg;
    logic             fin_enz_reg;
    logic [POS_W-1:0] fin_site_reg;

    // output stage
    logic      out_vld_reg;
    qmst_out_t out_reg, out_next;

    // handshake chain
    logic out_free, fin_adv, fin_free, in_adv;

    // score datapath
    logic [ROM_W-1:0]        err;
    logic signed [SUM_W-1:0] sum;
    logic [SCORE_W-1:0]      score;

    // finish datapath
    logic [POS_W-1:0]        beg;
    logic [POS_W-1:0]        end_inc;
    logic signed [POS_W+1:0] span;

    // move requests along the stages
    assign out_free = !out_vld_reg || m_ready;
    assign fin_adv  = fin_vld_reg && out_free;
    assign fin_free = !fin_vld_reg || fin_adv;
    assign in_adv   = in_vld_reg && (!in_reg.last_base || fin_free);
    assign s_ready  = !in_vld_reg || in_adv;

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= THR_RESET;
            min_len_reg <= MIN_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ERROR_THRESHOLD: thr_reg     <= cfg_wr_data[THR_W-1:0];
                REG_MIN_KEPT_LENGTH: min_len_reg <= cfg_wr_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // hold the incoming request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    // add the margin minus the error word, clamp, track the best run
    always_comb begin
        err   = err_word(in_reg.quality);
        sum   = $signed({2'b00, run_score_reg}) + $signed({(SUM_W-THR_W)'(0), thr_reg})
              - $signed({(SUM_W-ROM_W)'(0), err});
        score = '0;

        run_score_next  = run_score_reg;
        best_score_next = best_score_reg;
        run_start_next  = run_start_reg;
        best_begin_next = best_begin_reg;
        best_end_next   = best_end_reg;
        count_next      = count_reg;

        if (count_reg < READ_LIMIT) begin
            priority if (sum > $signed({2'b00, SCORE_MAX})) begin
                score = SCORE_MAX;
            end else if (sum <= 0) begin
                score          = '0;
                run_start_next = count_reg + POS_W'(1);
            end else begin
                score = sum[SCORE_W-1:0];
            end
            run_score_next = score;
            if (score > best_score_reg) begin
                best_begin_next = run_start_reg;
                best_end_next   = count_reg[IDX_W-1:0];
                best_score_next = score;
            end
            count_next = count_reg + POS_W'(1);
        end
    end

    // update the read state; clear it after the last base
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_score_reg  <= '0;
            best_score_reg <= '0;
            run_start_reg  <= '0;
            best_begin_reg <= '0;
            best_end_reg   <= '0;
            count_reg      <= '0;
        end else if (in_adv) begin
            if (in_reg.last_base) begin
                run_score_reg  <= '0;
                best_score_reg <= '0;
                run_start_reg  <= '0;
                best_begin_reg <= '0;
                best_end_reg   <= '0;
                count_reg      <= '0;
            end else begin
                run_score_reg  <= run_score_next;
                best_score_reg <= best_score_next;
                run_start_reg  <= run_start_next;
                best_begin_reg <= best_begin_next;
                best_end_reg   <= best_end_next;
                count_reg      <= count_next;
            end
        end
    end

    // capture the finished read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_vld_reg <= 1'b0;
        end else if (fin_free) begin
            fin_vld_reg <= in_adv && in_reg.last_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_free && in_adv && in_reg.last_base) begin
            fin_n_reg    <= count_next;
            fin_beg_reg  <= best_begin_next;
            fin_end_reg  <= best_end_next;
            fin_enz_reg  <= in_reg.enzyme_valid;
            fin_site_reg <= in_reg.enzyme_site;
        end
    end

    // apply the enzyme start, the end correction and the length filter
    always_comb begin
        beg = fin_beg_reg;
        if (fin_enz_reg && (fin_site_reg > fin_beg_reg)) begin
            beg = (fin_site_reg > {1'b0, fin_end_reg}) ? {1'b0, fin_end_reg} : fin_site_reg;
        end

        end_inc = {1'b0, fin_end_reg} + POS_W'(1);
        if (end_inc >= fin_n_reg) begin
            end_inc = fin_n_reg - POS_W'(1);
        end

        span = $signed({2'b00, end_inc}) - $signed({2'b00, beg}) + (POS_W+2)'(1);
        if (span < $signed({2'b00, min_len_reg})) begin
            beg     = '0;
            end_inc = '0;
        end

        out_next.left_trim_point  = beg;
        out_next.right_trim_point = fin_n_reg - end_inc;
        out_next.last_kept        = end_inc[IDX_W-1:0];
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= fin_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_adv) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire
